// ----- rtl/scharr_pkg.sv -----
package scharr_pkg;

  localparam int unsigned DefMaxWidth  = 1024;
  localparam int unsigned DefPixelBits = 8;
  localparam int unsigned EdgeBits     = 7;
  localparam int unsigned ImgWidthBits = 11;
  localparam int unsigned ImgHeightBits = 16;
  localparam int unsigned ApbAddrBits  = 3;
  localparam int unsigned ApbDataBits  = 32;
  localparam int unsigned QueueDepth   = 4;

  localparam logic OpPixel = 1'b0;
  localparam logic OpFlush = 1'b1;

  localparam logic RegWidth  = 1'b0;
  localparam logic RegHeight = 1'b1;

  // Gradient width for a given pixel width: |G| < 16 * 2^PB, plus sign.
  function automatic int unsigned grad_bits(int unsigned pb);
    return pb + 5;
  endfunction

endpackage

// ----- rtl/scharr_front.sv -----
module scharr_front #(
  parameter int unsigned MAX_WIDTH  = scharr_pkg::DefMaxWidth,
  parameter int unsigned PIXEL_BITS = scharr_pkg::DefPixelBits
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic [$clog2(MAX_WIDTH):0]                    width_i,
  input  logic [scharr_pkg::ImgHeightBits-1:0]          height_i,
  input  logic                                          restart_i,
  input  logic                                          valid_i,
  output logic                                          stall_o,
  input  logic                                          operation_i,
  input  logic [PIXEL_BITS-1:0]                         pixel_i,
  output logic                                          push_o,
  output logic                                          push_interior_o,
  output logic                                          push_frame_end_o,
  output logic signed [scharr_pkg::grad_bits(PIXEL_BITS)-1:0] push_gx_o,
  output logic signed [scharr_pkg::grad_bits(PIXEL_BITS)-1:0] push_gy_o,
  input  logic                                          full_i
);
  import scharr_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = CW + 1;
  localparam int unsigned PW = CW + 2;
  localparam int unsigned HB = ImgHeightBits;
  localparam int unsigned PB = PIXEL_BITS;
  localparam int unsigned GB = grad_bits(PIXEL_BITS);

  logic [CW-1:0] col_q, col_d;
  logic [HB-1:0] row_q, row_d;
  logic [PW-1:0] pend_q, pend_d;

  logic          s1_valid_q;
  logic          s1_op_q, s1_give_q, s1_int_q, s1_fe_q;
  logic [PB-1:0] s1_pix_q;
  logic [CW-1:0] s1_col_q;

  logic [2*PB-1:0] lb_mem [MAX_WIDTH];
  logic [2*PB-1:0] lb_rd_q;
  logic [PB-1:0]   win_q [6];

  logic accept, s1_adv;
  logic give, interior, frame_end;
  logic [PW-1:0] w_ext;
  logic [WW-1:0] col_inc;
  logic [HB:0]   row_inc;

  assign s1_adv  = s1_valid_q && (!s1_give_q || !full_i);
  assign stall_o = s1_valid_q && !s1_adv;
  assign accept  = valid_i && !stall_o;

  assign w_ext   = PW'(width_i);
  assign col_inc = WW'(col_q) + WW'(1);
  assign row_inc = (HB+1)'(row_q) + (HB+1)'(1);

  // A pixel's result belongs to the pixel one row and one column back.
  always_comb begin
    give      = 1'b0;
    interior  = 1'b0;
    frame_end = 1'b0;
    col_d     = col_q;
    row_d     = row_q;
    pend_d    = pend_q;
    if (operation_i == OpPixel) begin
      give      = (pend_q >= w_ext + PW'(1));
      interior  = (row_q >= HB'(2)) && (col_q >= CW'(2));
      frame_end = (col_q == '0) && (row_q == HB'(1));
      if (!give) begin
        pend_d = pend_q + PW'(1);
      end
      if (col_inc >= width_i) begin
        col_d = '0;
        row_d = (row_inc >= (HB+1)'(height_i)) ? '0 : row_inc[HB-1:0];
      end else begin
        col_d = col_inc[CW-1:0];
      end
    end else begin
      give      = (pend_q != '0);
      frame_end = ((row_q == '0) && (pend_q == PW'(col_q) + PW'(1))) ||
                  ((row_q == HB'(1)) && (col_q == '0) && (pend_q == w_ext + PW'(1)));
      if (give) begin
        pend_d = pend_q - PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      pend_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (restart_i) begin
        col_q  <= '0;
        row_q  <= '0;
        pend_q <= '0;
      end else if (accept) begin
        col_q  <= col_d;
        row_q  <= row_d;
        pend_q <= pend_d;
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q   <= operation_i;
      s1_give_q <= give;
      s1_int_q  <= interior;
      s1_fe_q   <= frame_end;
      s1_pix_q  <= pixel_i;
      s1_col_q  <= col_q;
      lb_rd_q   <= lb_mem[col_q];
    end
    if (s1_adv && (s1_op_q == OpPixel)) begin
      lb_mem[s1_col_q] <= {lb_rd_q[PB-1:0], s1_pix_q};
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= lb_rd_q[2*PB-1:PB];
      win_q[4] <= lb_rd_q[PB-1:0];
      win_q[5] <= s1_pix_q;
    end
  end

  logic signed [GB-1:0] at, am, ab, bt, bb, ct, cm, cb;

  always_comb begin
    at = GB'(win_q[0]);
    am = GB'(win_q[1]);
    ab = GB'(win_q[2]);
    bt = GB'(win_q[3]);
    bb = GB'(win_q[5]);
    ct = GB'(lb_rd_q[2*PB-1:PB]);
    cm = GB'(lb_rd_q[PB-1:0]);
    cb = GB'(s1_pix_q);
    push_gx_o = GB'(3) * (ct - at) + GB'(10) * (cm - am) + GB'(3) * (cb - ab);
    push_gy_o = GB'(3) * at + GB'(10) * bt + GB'(3) * ct
              - GB'(3) * ab - GB'(10) * bb - GB'(3) * cb;
  end

  assign push_o           = s1_valid_q && s1_give_q && !full_i;
  assign push_interior_o  = s1_int_q && (s1_op_q == OpPixel);
  assign push_frame_end_o = s1_fe_q;

endmodule

// ----- rtl/scharr_queue.sv -----
module scharr_queue #(
  parameter int unsigned DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output logic [DW-1:0] pop_data_o
);
  import scharr_pkg::*;

  localparam int unsigned AW = $clog2(QueueDepth);

  logic [DW-1:0] mem_q [QueueDepth];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   cnt_q;

  assign full_o     = (cnt_q == (AW+1)'(QueueDepth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + AW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (AW+1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/scharr_back.sv -----
module scharr_back #(
  parameter int unsigned PIXEL_BITS = scharr_pkg::DefPixelBits
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          empty_i,
  output logic                                          pop_o,
  input  logic                                          interior_i,
  input  logic                                          frame_end_i,
  input  logic signed [scharr_pkg::grad_bits(PIXEL_BITS)-1:0] gx_i,
  input  logic signed [scharr_pkg::grad_bits(PIXEL_BITS)-1:0] gy_i,
  output logic                                          valid_o,
  input  logic                                          stall_i,
  output logic [scharr_pkg::EdgeBits-1:0]               edge_value_o,
  output logic                                          frame_end_o
);
  import scharr_pkg::*;

  localparam int unsigned GB  = grad_bits(PIXEL_BITS);
  localparam int unsigned SB  = 2 * PIXEL_BITS + 9;
  localparam int unsigned N1  = (SB + 1) / 2;
  localparam int unsigned N2  = (N1 + 1) / 2;
  localparam int unsigned CNW = $clog2(N1 + 1);
  localparam logic [SB-1:0] Top1 = SB'(1) << (2 * (N1 - 1));
  localparam logic [SB-1:0] Top2 = SB'(1) << (2 * (N2 - 1));

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StAdd  = 3'd2;
  localparam logic [2:0] StRt1  = 3'd3;
  localparam logic [2:0] StRt2  = 3'd4;
  localparam logic [2:0] StDone = 3'd5;

  logic [2:0]           st_q;
  logic signed [GB-1:0] gx_q, gy_q;
  logic [2*GB-1:0]      sqx_q, sqy_q;
  logic [SB-1:0]        v_q, res_q, bit_q;
  logic [CNW-1:0]       cnt_q;
  logic                 fe_q;
  logic                 out_valid_q;
  logic [EdgeBits-1:0]  out_val_q;
  logic                 out_fe_q;

  logic [SB:0]   trial;
  logic [SB-1:0] v_nx, res_nx;
  logic          out_free;
  logic signed [2*GB-1:0] gx_w, gy_w;

  assign gx_w = (2*GB)'(gx_q);
  assign gy_w = (2*GB)'(gy_q);

  // One digit of the bit-pair square root per cycle.
  always_comb begin
    trial = (SB+1)'(res_q) + (SB+1)'(bit_q);
    if ((SB+1)'(v_q) >= trial) begin
      v_nx   = v_q - trial[SB-1:0];
      res_nx = (res_q >> 1) + bit_q;
    end else begin
      v_nx   = v_q;
      res_nx = res_q >> 1;
    end
  end

  assign out_free = !out_valid_q || !stall_i;
  assign pop_o    = (st_q == StIdle) && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (st_q)
        StIdle: if (!empty_i) st_q <= interior_i ? StMul : StDone;
        StMul:  st_q <= StAdd;
        StAdd:  st_q <= StRt1;
        StRt1:  if (cnt_q == CNW'(1)) st_q <= StRt2;
        StRt2:  if (cnt_q == CNW'(1)) st_q <= StDone;
        StDone: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            st_q        <= StIdle;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      StIdle: begin
        gx_q  <= gx_i;
        gy_q  <= gy_i;
        fe_q  <= frame_end_i;
        res_q <= '0;
      end
      StMul: begin
        sqx_q <= $unsigned(gx_w * gx_w);
        sqy_q <= $unsigned(gy_w * gy_w);
      end
      StAdd: begin
        v_q   <= sqx_q[SB-1:0] + sqy_q[SB-1:0];
        res_q <= '0;
        bit_q <= Top1;
        cnt_q <= CNW'(N1);
      end
      StRt1: begin
        if (cnt_q == CNW'(1)) begin
          v_q   <= res_nx;
          res_q <= '0;
          bit_q <= Top2;
          cnt_q <= CNW'(N2);
        end else begin
          v_q   <= v_nx;
          res_q <= res_nx;
          bit_q <= bit_q >> 2;
          cnt_q <= cnt_q - CNW'(1);
        end
      end
      StRt2: begin
        v_q   <= v_nx;
        res_q <= res_nx;
        bit_q <= bit_q >> 2;
        cnt_q <= cnt_q - CNW'(1);
      end
      StDone: begin
        if (out_free) begin
          out_val_q <= res_q[EdgeBits-1:0];
          out_fe_q  <= fe_q;
        end
      end
      default: ;
    endcase
  end

  assign valid_o      = out_valid_q;
  assign edge_value_o = out_val_q;
  assign frame_end_o  = out_fe_q;

endmodule

// ----- rtl/scharr_edge_magnitude_core.sv -----
// Scharr 3x3 edge magnitude over a raster stream of grey pixels.
// Input channel: valid_i/stall_o with operation_i and pixel_i. A pixel item
// feeds the line buffers; a flush item drains one owed result at frame end.
// Output channel: valid_o/stall_i with edge_value_o (floor fourth root of
// Gx^2+Gy^2, zero on border pixels) and frame_end_o on the frame's last pixel.
// A pixel's result is released by the pixel width+1 places later, or by a
// flush; the first width+1 pixels of a run give no word.
// The front end takes one item per cycle while its four-entry queue has room.
// Each word for an interior pixel goes through one shared square-root unit
// that settles one result bit per cycle, for the first root and then for the
// second. An interior word holds the back end through its pop, multiply, add,
// first-root, second-root and output states, and its result is registered in
// the output register together with valid_o. Border words go from the pop
// state straight to the output state.
// A held output word stays stable while stall_i is high; the back end waits,
// then the queue fills and stall_o rises.
// Reset clears the front end's position and pending counters, the queue and the output valid;
// width and height go to 512. Writing either register over APB restarts the frame position.
module scharr_edge_magnitude_core #(
  parameter int unsigned MAX_WIDTH  = scharr_pkg::DefMaxWidth,
  parameter int unsigned PIXEL_BITS = scharr_pkg::DefPixelBits
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [scharr_pkg::ApbAddrBits-1:0]    paddr,
  input  logic [scharr_pkg::ApbDataBits-1:0]    pwdata,
  output logic [scharr_pkg::ApbDataBits-1:0]    prdata,
  output logic                                  pready,
  input  logic                                  valid_i,
  output logic                                  stall_o,
  input  logic                                  operation_i,
  input  logic [PIXEL_BITS-1:0]                 pixel_i,
  output logic                                  valid_o,
  input  logic                                  stall_i,
  output logic [scharr_pkg::EdgeBits-1:0]       edge_value_o,
  output logic                                  frame_end_o
);
  import scharr_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned GB = grad_bits(PIXEL_BITS);
  localparam int unsigned QW = 2 * GB + 2;

  logic [ImgWidthBits-1:0]  img_width_q;
  logic [ImgHeightBits-1:0] img_height_q;
  logic                     wr_en;
  logic [15:0]              w16, weff16;
  logic [ImgHeightBits-1:0] heff;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_width_q  <= ImgWidthBits'(512);
      img_height_q <= ImgHeightBits'(512);
    end else if (wr_en) begin
      unique case (paddr[2])
        RegWidth:  img_width_q  <= pwdata[ImgWidthBits-1:0];
        RegHeight: img_height_q <= pwdata[ImgHeightBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegWidth:  prdata = ApbDataBits'(img_width_q);
      RegHeight: prdata = ApbDataBits'(img_height_q);
      default:   prdata = '0;
    endcase
  end

  assign w16    = 16'(img_width_q);
  assign weff16 = (w16 < 16'd3) ? 16'd3 :
                  (w16 > 16'(MAX_WIDTH)) ? 16'(MAX_WIDTH) : w16;
  assign heff   = (img_height_q < ImgHeightBits'(3)) ? ImgHeightBits'(3) : img_height_q;

  logic                 push, full, pop, empty;
  logic                 push_int, push_fe;
  logic signed [GB-1:0] push_gx, push_gy;
  logic [QW-1:0]        q_in, q_out;

  scharr_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .PIXEL_BITS(PIXEL_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .width_i         (weff16[CW:0]),
    .height_i        (heff),
    .restart_i       (wr_en),
    .valid_i         (valid_i),
    .stall_o         (stall_o),
    .operation_i     (operation_i),
    .pixel_i         (pixel_i),
    .push_o          (push),
    .push_interior_o (push_int),
    .push_frame_end_o(push_fe),
    .push_gx_o       (push_gx),
    .push_gy_o       (push_gy),
    .full_i          (full)
  );

  assign q_in = {push_int, push_fe, push_gx, push_gy};

  scharr_queue #(
    .DW(QW)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(q_in),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .pop_data_o (q_out)
  );

  scharr_back #(
    .PIXEL_BITS(PIXEL_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .pop_o       (pop),
    .interior_i  (q_out[QW-1]),
    .frame_end_i (q_out[QW-2]),
    .gx_i        (q_out[2*GB-1:GB]),
    .gy_i        (q_out[GB-1:0]),
    .valid_o     (valid_o),
    .stall_i     (stall_i),
    .edge_value_o(edge_value_o),
    .frame_end_o (frame_end_o)
  );

endmodule
